[rtl/wsu_pkg.sv]
`default_nettype none

package wsu_pkg;

  // header bit fields and length codes
  localparam logic [7:0] FIN_BIT      = 8'h80;
  localparam logic [7:0] MASK_BIT     = 8'h80;
  localparam logic [7:0] LEN_CODE_MSK = 8'h7F;
  localparam logic [6:0] LEN_CODE_16  = 7'd126;
  localparam logic [6:0] LEN_CODE_64  = 7'd127;

  // extended length byte counts, taken modulo eight
  localparam logic [2:0] EXT16_BYTES  = 3'd2;
  localparam logic [2:0] EXT64_BYTES  = 3'd0;

  localparam int unsigned LEN_W  = 64;
  localparam int unsigned KEY_W  = 32;

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXT16   = 3'd2,
    PH_EXT64   = 3'd3,
    PH_MASK    = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_SKIP    = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    ST_DATA      = 3'd0,
    ST_NOT_FINAL = 3'd1,
    ST_NOT_MASK  = 3'd2,
    ST_TRUNC     = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

endpackage

`default_nettype wire

[rtl/wsu_rx_if.sv]
`default_nettype none

interface wsu_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_of_buffer;

  modport source (output valid, output data_byte, output last_of_buffer, input ready);
  modport sink   (input valid, input data_byte, input last_of_buffer, output ready);
endinterface

`default_nettype wire

[rtl/wsu_tx_if.sv]
`default_nettype none

interface wsu_tx_if
  import wsu_pkg::*;
;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       last;
  status_t    status;

  modport source (output valid, output payload_byte, output last, output status, input ready);
  modport sink   (input valid, input payload_byte, input last, input status, output ready);
endinterface

`default_nettype wire

[rtl/websocket_frame_unmasker_core.sv]
`default_nettype none

// channel | dir | payload                          | request moves
// rx      | in  | data_byte, last_of_buffer        | one received frame byte
// tx      | out | payload_byte, last, status       | one unmasked byte or one status
//
// one byte per cycle sustained while tx is ready: a byte is first held in the input register,
// then the header/length/key state and the result register update together.
// from rx request to tx valid a byte passes the input register, then the result register.
// a stalled tx holds the result register; the input register keeps taking a
// byte whenever the result register is empty or being drained.
// rst is synchronous and returns the parser to the first header byte.
module websocket_frame_unmasker_core
  import wsu_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  wsu_rx_if.sink    rx,
  wsu_tx_if.source  tx
);

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_end;

  // parser state
  phase_t             phase, phase_next;
  logic [2:0]         ext_len_index, ext_len_index_next;
  logic [LEN_W-1:0]   remaining_len, remaining_len_next;
  logic [KEY_W-1:0]   mask_key, mask_key_next;
  logic [1:0]         mask_pos, mask_pos_next;

  // result register
  logic       res_valid;
  logic [7:0] res_byte;
  logic       res_last;
  status_t    res_status;

  logic       advance;
  logic       produce;
  logic [7:0] out_byte;
  logic       out_last;
  status_t    out_status;
  logic [2:0] ext_inc;
  logic [2:0] ext_need;
  logic [7:0] key_byte;

  assign advance  = in_valid && (!res_valid || tx.ready);
  assign rx.ready = !in_valid || advance;

  // input register load
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.ready) begin
      in_valid <= rx.valid;
    end
    if (rx.valid && rx.ready) begin
      in_byte <= rx.data_byte;
      in_end  <= rx.last_of_buffer;
    end
  end

  // mask byte for the current payload position
  always_comb begin
    unique case (mask_pos)
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
  end

  assign ext_inc  = ext_len_index + 3'd1;
  assign ext_need = (phase == PH_EXT16) ? EXT16_BYTES : EXT64_BYTES;

  // frame parser next state and result
  always_comb begin
    phase_next         = phase;
    ext_len_index_next = ext_len_index;
    remaining_len_next = remaining_len;
    mask_key_next      = mask_key;
    mask_pos_next      = mask_pos;
    produce            = 1'b0;
    out_byte           = 8'd0;
    out_last           = 1'b1;
    out_status         = ST_DATA;

    unique case (phase)
      PH_HDR0: begin
        ext_len_index_next = 3'd0;
        remaining_len_next = '0;
        mask_key_next      = '0;
        mask_pos_next      = 2'd0;
        priority if (in_end) begin
          phase_next = PH_HDR0;
          produce    = 1'b1;
          out_status = ST_TRUNC;
        end else if ((in_byte & FIN_BIT) == 8'd0) begin
          phase_next = PH_SKIP;
          produce    = 1'b1;
          out_status = ST_NOT_FINAL;
        end else begin
          phase_next = PH_HDR1;
        end
      end

      PH_HDR1: begin
        priority if ((in_byte & MASK_BIT) == 8'd0) begin
          phase_next = in_end ? PH_HDR0 : PH_SKIP;
          produce    = 1'b1;
          out_status = ST_NOT_MASK;
        end else if (in_end) begin
          phase_next = PH_HDR0;
          produce    = 1'b1;
          out_status = ST_TRUNC;
        end else begin
          ext_len_index_next = 3'd0;
          priority if (in_byte[6:0] == LEN_CODE_16) begin
            remaining_len_next = '0;
            phase_next         = PH_EXT16;
          end else if (in_byte[6:0] == LEN_CODE_64) begin
            remaining_len_next = '0;
            phase_next         = PH_EXT64;
          end else begin
            remaining_len_next = {{(LEN_W-7){1'b0}}, in_byte[6:0]};
            mask_pos_next      = 2'd0;
            phase_next         = PH_MASK;
          end
        end
      end

      PH_EXT16, PH_EXT64: begin
        remaining_len_next = {remaining_len[LEN_W-9:0], in_byte};
        ext_len_index_next = ext_inc;
        priority if (in_end) begin
          phase_next = PH_HDR0;
          produce    = 1'b1;
          out_status = ST_TRUNC;
        end else if (ext_inc == ext_need) begin
          ext_len_index_next = 3'd0;
          mask_pos_next      = 2'd0;
          phase_next         = PH_MASK;
        end else begin
          phase_next = phase;
        end
      end

      PH_MASK: begin
        mask_key_next = {mask_key[KEY_W-9:0], in_byte};
        mask_pos_next = mask_pos + 2'd1;
        priority if (mask_pos == 2'd3 && remaining_len == '0) begin
          phase_next = in_end ? PH_HDR0 : PH_SKIP;
          produce    = 1'b1;
          out_status = ST_EMPTY;
        end else if (in_end) begin
          phase_next = PH_HDR0;
          produce    = 1'b1;
          out_status = ST_TRUNC;
        end else if (mask_pos == 2'd3) begin
          phase_next = PH_PAYLOAD;
        end else begin
          phase_next = PH_MASK;
        end
      end

      PH_PAYLOAD: begin
        remaining_len_next = remaining_len - {{(LEN_W-1){1'b0}}, 1'b1};
        mask_pos_next      = mask_pos + 2'd1;
        produce            = 1'b1;
        priority if (remaining_len == {{(LEN_W-1){1'b0}}, 1'b1}) begin
          phase_next = in_end ? PH_HDR0 : PH_SKIP;
          out_byte   = in_byte ^ key_byte;
          out_last   = 1'b1;
        end else if (in_end) begin
          phase_next = PH_HDR0;
          out_status = ST_TRUNC;
        end else begin
          out_byte = in_byte ^ key_byte;
          out_last = 1'b0;
        end
      end

      default: begin
        phase_next = in_end ? PH_HDR0 : PH_SKIP;
      end
    endcase
  end

  // parser state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HDR0;
      ext_len_index <= 3'd0;
      remaining_len <= '0;
      mask_key      <= '0;
      mask_pos      <= 2'd0;
    end else if (advance) begin
      phase         <= phase_next;
      ext_len_index <= ext_len_index_next;
      remaining_len <= remaining_len_next;
      mask_key      <= mask_key_next;
      mask_pos      <= mask_pos_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= produce;
    end else if (tx.ready) begin
      res_valid <= 1'b0;
    end
    if (advance && produce) begin
      res_byte   <= out_byte;
      res_last   <= out_last;
      res_status <= out_status;
    end
  end

  assign tx.valid        = res_valid;
  assign tx.payload_byte = res_byte;
  assign tx.last         = res_last;
  assign tx.status       = res_status;

  // checks
  a_status_ends_frame: assert property (@(posedge clk) disable iff (rst)
    (tx.valid && tx.status != ST_DATA) |-> tx.last)
    else $error("status result without last");

  a_status_no_data: assert property (@(posedge clk) disable iff (rst)
    (tx.valid && tx.status != ST_DATA) |-> (tx.payload_byte == 8'd0))
    else $error("status result carries payload data");

  a_payload_len_live: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAYLOAD) |-> (remaining_len != '0))
    else $error("payload phase with no bytes left");

  a_reset_phase: assert property (@(posedge clk)
    rst |=> (phase == PH_HDR0 && !tx.valid))
    else $error("parser not idle after reset");

endmodule

`default_nettype wire
